@@ hdl/wsd_pkg.sv @@
// shared types and constants for the websocket frame deframer
`default_nettype none
package wsd_pkg;

	// header parse phase
	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_MASK    = 3'd3,
		PH_PAYLOAD = 3'd4
	} wsd_phase_t;

	// length encoding of the current frame
	typedef enum logic [1:0] {
		LF_7  = 2'd0,
		LF_16 = 2'd1,
		LF_64 = 2'd2
	} wsd_len_form_t;

	localparam logic [7:0] MASK_BIT  = 8'h80;
	localparam logic [6:0] LEN_IS_16 = 7'd126;
	localparam logic [6:0] LEN_IS_64 = 7'd127;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	// one result item from the parser
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
		logic       empty;
	} wsd_result_t;

endpackage
`default_nettype wire

@@ hdl/wsd_in_stage.sv @@
// input register stage with handshake toward the upstream side
`default_nettype none
module wsd_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       out_free,
	output logic            advance,
	output logic [7:0]      byte_s1
);

	logic valid_s1;

	// the held item moves on whenever the result register can take it
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule
`default_nettype wire

@@ hdl/wsd_parser.sv @@
// frame header parser, length counter and payload unmasking
`default_nettype none
module wsd_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         advance,
	input  wire logic [7:0]   byte_s1,
	output wsd_pkg::wsd_result_t result
);

	wsd_pkg::wsd_phase_t    phase_q, phase_d;
	wsd_pkg::wsd_len_form_t form_q, form_d;
	logic [3:0]  hpos_q, hpos_d, hpos_inc;
	logic [63:0] remain_q, remain_d;
	logic        mask_q, mask_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  kidx_q, kidx_d;
	logic [7:0]  key_byte;
	logic [3:0]  ext_need;

	assign hpos_inc = hpos_q + 4'd1;
	assign ext_need = (form_q == wsd_pkg::LF_16) ? wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;

	// key byte for the current payload byte, first key byte highest
	always_comb begin
		case (kidx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next state and result
	always_comb begin
		phase_d  = phase_q;
		form_d   = form_q;
		hpos_d   = hpos_q;
		remain_d = remain_q;
		mask_d   = mask_q;
		key_d    = key_q;
		kidx_d   = kidx_q;
		result   = '0;
		unique case (phase_q)
			wsd_pkg::PH_SECOND: begin
				mask_d = (byte_s1 & wsd_pkg::MASK_BIT) != 8'd0;
				key_d  = '0;
				hpos_d = '0;
				if (byte_s1[6:0] == wsd_pkg::LEN_IS_16) begin
					form_d   = wsd_pkg::LF_16;
					remain_d = '0;
					phase_d  = wsd_pkg::PH_EXTLEN;
				end else if (byte_s1[6:0] == wsd_pkg::LEN_IS_64) begin
					form_d   = wsd_pkg::LF_64;
					remain_d = '0;
					phase_d  = wsd_pkg::PH_EXTLEN;
				end else begin
					form_d   = wsd_pkg::LF_7;
					remain_d = {57'd0, byte_s1[6:0]};
					if (mask_d) begin
						phase_d = wsd_pkg::PH_MASK;
					end else begin
						kidx_d = '0;
						if (remain_d == 64'd0) begin
							result  = '{valid: 1'b1, data: 8'd0, last: 1'b1, empty: 1'b1};
							phase_d = wsd_pkg::PH_FIRST;
						end else begin
							phase_d = wsd_pkg::PH_PAYLOAD;
						end
					end
				end
			end
			wsd_pkg::PH_EXTLEN: begin
				remain_d = {remain_q[55:0], byte_s1};
				hpos_d   = hpos_inc;
				if (hpos_inc >= ext_need) begin
					hpos_d = '0;
					if (mask_q) begin
						phase_d = wsd_pkg::PH_MASK;
					end else begin
						kidx_d = '0;
						if (remain_d == 64'd0) begin
							result  = '{valid: 1'b1, data: 8'd0, last: 1'b1, empty: 1'b1};
							phase_d = wsd_pkg::PH_FIRST;
						end else begin
							phase_d = wsd_pkg::PH_PAYLOAD;
						end
					end
				end
			end
			wsd_pkg::PH_MASK: begin
				key_d  = {key_q[23:0], byte_s1};
				hpos_d = hpos_inc;
				if (hpos_inc >= wsd_pkg::KEY_BYTES) begin
					hpos_d = '0;
					kidx_d = '0;
					if (remain_q == 64'd0) begin
						result  = '{valid: 1'b1, data: 8'd0, last: 1'b1, empty: 1'b1};
						phase_d = wsd_pkg::PH_FIRST;
					end else begin
						phase_d = wsd_pkg::PH_PAYLOAD;
					end
				end
			end
			wsd_pkg::PH_PAYLOAD: begin
				kidx_d       = kidx_q + 2'd1;
				remain_d     = remain_q - 64'd1;
				result.valid = 1'b1;
				result.data  = mask_q ? (byte_s1 ^ key_byte) : byte_s1;
				result.last  = (remain_q == 64'd1);
				if (remain_q == 64'd1) begin
					phase_d = wsd_pkg::PH_FIRST;
				end
			end
			default: begin
				// first header byte, and unused codes, carry nothing we keep
				phase_d = wsd_pkg::PH_SECOND;
				hpos_d  = '0;
			end
		endcase
		if (!advance) begin
			result.valid = 1'b0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsd_pkg::PH_FIRST;
			form_q   <= wsd_pkg::LF_7;
			hpos_q   <= '0;
			remain_q <= '0;
			mask_q   <= 1'b0;
			key_q    <= '0;
			kidx_q   <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			form_q   <= form_d;
			hpos_q   <= hpos_d;
			remain_q <= remain_d;
			mask_q   <= mask_d;
			key_q    <= key_d;
			kidx_q   <= kidx_d;
		end
	end

endmodule
`default_nettype wire

@@ hdl/wsd_out_stage.sv @@
// result register toward the downstream side
`default_nettype none
module wsd_out_stage (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire wsd_pkg::wsd_result_t result,
	output logic                     out_free,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [7:0]               out_data,
	output logic                     out_last,
	output logic                     out_empty
);

	logic out_valid_q;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// valid flag: loaded on advance, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			out_data  <= result.data;
			out_last  <= result.last;
			out_empty <= result.empty;
		end
	end

endmodule
`default_nettype wire

@@ hdl/websocket_frame_deframer_unit.sv @@
// A payload byte is offered on the master side after the input register and the result register.
// Throughput: one byte per cycle while the master side does not stall, set by the header
// and length update in the parser between the input register and the result register.
// Header bytes give no item, except the one that ends the header of an empty frame.
// Reset (arst_n low, asynchronous) returns the parser to the first header byte
// and empties both registers.
`default_nettype none
module websocket_frame_deframer_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] in_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] payload_byte
	output logic            m_axis_tlast,
	output logic            m_axis_tuser   // [0] empty_message
);

	logic                 advance;
	logic                 out_free;
	logic [7:0]           byte_s1;
	wsd_pkg::wsd_result_t result;

	wsd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.out_free (out_free),
		.advance  (advance),
		.byte_s1  (byte_s1)
	);

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.result  (result)
	);

	wsd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.result    (result),
		.out_free  (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_empty (m_axis_tuser)
	);

endmodule
`default_nettype wire

@@ hdl/wsd_checker.sv @@
// port-level checks for the deframer, bound to the top level
`default_nettype none
module wsd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tlast,
	input wire logic       m_axis_tuser
);

	// a stalled item holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("stalled output item changed");

	// an empty frame item is zero and closes the frame
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
		else $error("empty frame item malformed");

	// nothing offered while in reset
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

	// with the result register empty the input side never stalls
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with free result register");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
